>>> hdl/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared codes, widths and controller/datapath interface types for the
// sorted array priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sapq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int ECNT_W   = 5;

  localparam int IN_TDATA_W  = 72;  // 68 bits of fields, padded to bytes
  localparam int IN_TUSER_W  = KIND_W;
  localparam int OUT_TDATA_W = 40;

  // operation kinds
  localparam logic [KIND_W-1:0] KIND_PUSH  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FIND  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic                load;    // request accepted, capture the result
    logic                push;
    logic                pop;
    logic                find;
    logic                read;
    logic                clear;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_ok;   // requested index lies below the entry count
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/sorted_array_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Bounded min-priority queue of value/priority pairs kept in sorted cells.
// ----------------------------------------------------------------------------
//  channel | ports                          | contents
//  in      | in_tvalid/in_tready/in_tdata   | value, priority_req, index
//          | in_tuser                       | kind
//  out     | out_tvalid/out_tready/out_tdata| result_value, found, status,
//          |                                | entry_count
//
//  Each request executes in the cycle it is accepted; its result shows on
//  out_* in the next cycle. The single output register sets the rate: one
//  request per cycle while the sink takes each result as it appears; while
//  a result waits, the next request can enter only as that result leaves.
//  A stalled result holds; in_tready then drops until it is taken.
//  Reset empties the queue; stored cells are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_priority_queue #(
  parameter int DEPTH = sapq_pkg::DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [31:0] value, [63:32] priority_req, [67:64] index, [71:68] zero
  input  wire [sapq_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [2:0] kind
  input  wire [sapq_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [31:0] result_value, [32] found, [34:33] status, [39:35] entry_count
  output logic [sapq_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import sapq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [VALUE_W-1:0]  result_value;
  logic                found;
  logic [STATUS_W-1:0] status;
  logic [ECNT_W-1:0]   entry_count;

  sapq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .kind       (in_tuser[KIND_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sapq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_value     (in_tdata[31:0]),
    .in_prio      (in_tdata[63:32]),
    .in_index     (in_tdata[67:64]),
    .sts          (sts),
    .result_value (result_value),
    .found        (found),
    .status       (status),
    .entry_count  (entry_count)
  );

  assign out_tdata = {entry_count, status, found, result_value};

endmodule

`default_nettype wire

>>> hdl/sapq_ctrl.sv
// ----------------------------------------------------------------------------
// sapq_ctrl
// Request decode, status selection and output register handshake control.
// ----------------------------------------------------------------------------
`default_nettype none

module sapq_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire [sapq_pkg::KIND_W-1:0]   kind,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  input  sapq_pkg::sts_t               sts,
  output sapq_pkg::cmd_t               cmd
);
  import sapq_pkg::*;

  localparam logic S_IDLE = 1'b0;  // output register empty
  localparam logic S_HOLD = 1'b1;  // result waiting for the sink

  logic state_r, state_nxt;
  logic accept;

  // a new request may enter in the same cycle the held result leaves
  assign in_tready  = (state_r == S_IDLE) || out_tready;
  assign out_tvalid = (state_r == S_HOLD);
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_HOLD : S_IDLE;
      S_HOLD:  state_nxt = (out_tready && !accept) ? S_IDLE : S_HOLD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.status = ST_OK;
    case (kind)
      KIND_PUSH: begin
        if (sts.full) cmd.status = ST_FULL;
        else          cmd.push   = accept;
      end
      KIND_POP: begin
        if (sts.empty) cmd.status = ST_EMPTY;
        else           cmd.pop    = accept;
      end
      KIND_FIND:  cmd.find  = accept;
      KIND_READ: begin
        if (sts.idx_ok) cmd.read   = accept;
        else            cmd.status = ST_RANGE;
      end
      KIND_CLEAR: cmd.clear = accept;
      default:    ;
    endcase
  end

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push, cmd.pop, cmd.find, cmd.read, cmd.clear}))
    else $error("more than one operation issued");

  a_op_needs_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push || cmd.pop || cmd.find || cmd.read || cmd.clear) |-> cmd.load)
    else $error("operation issued without an accepted request");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_tvalid)
    else $error("accepted request produced no result");

endmodule

`default_nettype wire

>>> hdl/sapq_dp.sv
// ----------------------------------------------------------------------------
// sapq_dp
// Row of compare-and-shift cells holding entries in ascending priority,
// the entry count, and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module sapq_dp #(
  parameter int DEPTH = sapq_pkg::DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  sapq_pkg::cmd_t                   cmd,
  input  wire [sapq_pkg::VALUE_W-1:0]      in_value,
  input  wire [sapq_pkg::PRIO_W-1:0]       in_prio,
  input  wire [sapq_pkg::INDEX_W-1:0]      in_index,
  output sapq_pkg::sts_t                   sts,
  output logic [sapq_pkg::VALUE_W-1:0]     result_value,
  output logic                             found,
  output logic [sapq_pkg::STATUS_W-1:0]    status,
  output logic [sapq_pkg::ECNT_W-1:0]      entry_count
);
  import sapq_pkg::*;

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int RDN = (DEPTH < (1 << INDEX_W)) ? DEPTH : (1 << INDEX_W);

  logic        [VALUE_W-1:0] val_r  [DEPTH];
  logic        [VALUE_W-1:0] val_nxt[DEPTH];
  logic signed [PRIO_W-1:0]  pri_r  [DEPTH];
  logic signed [PRIO_W-1:0]  pri_nxt[DEPTH];
  logic [CW-1:0]             count_r, count_nxt;

  logic [DEPTH-1:0]    gt;      // occupied cell with strictly larger priority
  logic [DEPTH-1:0]    gt_up;   // gt of the cell below
  logic [DEPTH-1:0]    hit;
  logic [VALUE_W-1:0]  rd_val;
  logic [CW+INDEX_W-1:0] idx_ext, cnt_ext;
  logic [CW+ECNT_W-1:0]  ecnt_ext;

  logic [VALUE_W-1:0]  res_value_r, res_value_nxt;
  logic                found_r, found_nxt;
  logic [STATUS_W-1:0] status_r;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i]  = (CW'(i) < count_r) && (pri_r[i] > $signed(in_prio));
      hit[i] = (CW'(i) < count_r) && (val_r[i] == in_value);
    end
  end

  assign gt_up = {gt[DEPTH-2:0], 1'b0};

  always_comb begin
    rd_val = '0;
    for (int i = 0; i < RDN; i++) begin
      if (in_index == INDEX_W'(i)) rd_val = val_r[i];
    end
  end

  assign idx_ext = {{CW{1'b0}}, in_index};
  assign cnt_ext = {{INDEX_W{1'b0}}, count_r};

  assign sts.full   = (count_r == CW'(DEPTH));
  assign sts.empty  = (count_r == '0);
  assign sts.idx_ok = (idx_ext < cnt_ext);

  // cell updates
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      val_nxt[i] = val_r[i];
      pri_nxt[i] = pri_r[i];
    end
    if (cmd.push) begin
      // larger entries move up one place; new entry lands after equals
      for (int i = 0; i < DEPTH; i++) begin
        if (gt_up[i]) begin
          val_nxt[i] = val_r[i-1 < 0 ? 0 : i-1];
          pri_nxt[i] = pri_r[i-1 < 0 ? 0 : i-1];
        end else if (gt[i] || CW'(i) == count_r) begin
          val_nxt[i] = in_value;
          pri_nxt[i] = $signed(in_prio);
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        val_nxt[i] = val_r[i+1];
        pri_nxt[i] = pri_r[i+1];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push)       count_nxt = count_r + 1'b1;
    else if (cmd.pop)   count_nxt = count_r - 1'b1;
    else if (cmd.clear) count_nxt = '0;
  end

  always_comb begin
    res_value_nxt = '0;
    if (cmd.pop)       res_value_nxt = val_r[0];
    else if (cmd.read) res_value_nxt = rd_val;
    found_nxt = cmd.find && (|hit);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      val_r[i] <= val_nxt[i];
      pri_r[i] <= pri_nxt[i];
    end
    if (cmd.load) begin
      res_value_r <= res_value_nxt;
      found_r     <= found_nxt;
      status_r    <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign ecnt_ext     = {{ECNT_W{1'b0}}, count_r};
  assign entry_count  = ecnt_ext[ECNT_W-1:0];
  assign result_value = res_value_r;
  assign found        = found_r;
  assign status       = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && cmd.push |=> count_r == $past(count_r) + 1'b1)
    else $error("push did not add one entry");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && cmd.clear |=> count_r == '0)
    else $error("clear left entries");

  a_head_is_min: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > CW'(1)) |-> (pri_r[0] <= pri_r[1]))
    else $error("head entry out of order");

endmodule

`default_nettype wire
